### src/kqt_pkg.sv
// Package for the keyed quantity table: sizes, operation and status codes,
// beat structs and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package kqt_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W   = 16;
	localparam int CNT_W   = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W   = $clog2(ENTRIES + 1);

	// operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] item_key;
		logic [CNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] count_value;
		logic             hit;
		logic [1:0]       status;
		logic [4:0]       occupied;
		logic             table_empty;
	} rsp_t;

	typedef struct packed {
		logic capture;  // latch lookup results of the accepted beat
		logic commit;   // apply the update and load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic [OCC_W-1:0]   occ;
		logic [ENTRIES-1:0] valid_vec;
	} dp_st_t;

endpackage

### src/kqt_ctrl.sv
// Controller for the keyed quantity table: two-state sequencer and the
// result valid flag. Depends on kqt_pkg.
`timescale 1ns / 1ps

module kqt_ctrl
	import kqt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_UPDATE = 1'b1;

	logic state_q;
	logic rsp_valid_q;
	logic can_load;

	assign req_ready   = (state_q == S_IDLE);
	assign can_load    = !rsp_valid_q || rsp_ready;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == S_UPDATE) && can_load;
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/kqt_dp.sv
// Datapath for the keyed quantity table: key/count entry registers, parallel
// key match, free-entry choice, count update, occupancy and result register.
// Depends on kqt_pkg.
`timescale 1ns / 1ps

module kqt_dp
	import kqt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req_data,
	input  dp_cmd_t cmd,
	output rsp_t    rsp_data,
	output dp_st_t  st
);

	logic [KEY_W-1:0]   keys_q   [ENTRIES];
	logic [CNT_W-1:0]   counts_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0]   occ_q;

	// lookup results of the beat in flight
	logic [1:0]       kind_s1;
	logic [KEY_W-1:0] key_s1;
	logic [CNT_W-1:0] amount_s1;
	logic             hit_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             free_s1;
	logic [IDX_W-1:0] free_idx_s1;

	logic             hit_c, free_c;
	logic [IDX_W-1:0] idx_c, free_idx_c;

	logic             wr_en, wr_key_en, set_valid, clr_valid, clr_all;
	logic [IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] wr_cnt;
	logic [OCC_W-1:0] occ_next;
	logic [CNT_W:0]   sum;
	rsp_t             rsp_next;
	rsp_t             rsp_q;
	logic [OCC_W+4:0] occ_ext;

	// lowest matching and lowest free entry
	always_comb begin
		hit_c      = 1'b0;
		free_c     = 1'b0;
		idx_c      = '0;
		free_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && keys_q[i] == req_data.item_key) begin
				hit_c = 1'b1;
				idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_c     = 1'b1;
				free_idx_c = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1     <= req_data.kind;
			key_s1      <= req_data.item_key;
			amount_s1   <= req_data.amount;
			hit_s1      <= hit_c;
			idx_s1      <= idx_c;
			cnt_s1      <= counts_q[idx_c];
			free_s1     <= free_c;
			free_idx_s1 <= free_idx_c;
		end
	end

	assign sum = {1'b0, cnt_s1} + {1'b0, amount_s1};

	always_comb begin
		wr_en     = 1'b0;
		wr_key_en = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		clr_all   = 1'b0;
		wr_idx    = idx_s1;
		wr_cnt    = '0;
		occ_next  = occ_q;
		rsp_next  = '0;
		rsp_next.hit    = hit_s1;
		rsp_next.status = ST_OK;
		unique case (kind_s1)
			OP_ADD: begin
				if (hit_s1) begin
					wr_en  = 1'b1;
					wr_cnt = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
					rsp_next.count_value = wr_cnt;
				end else if (free_s1) begin
					wr_en     = 1'b1;
					wr_key_en = 1'b1;
					set_valid = 1'b1;
					wr_idx    = free_idx_s1;
					wr_cnt    = amount_s1;
					occ_next  = occ_q + OCC_W'(1);
					rsp_next.count_value = amount_s1;
				end else begin
					rsp_next.status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (hit_s1) begin
					if (amount_s1 >= cnt_s1) begin
						clr_valid = 1'b1;
						occ_next  = occ_q - OCC_W'(1);
					end else begin
						wr_en  = 1'b1;
						wr_cnt = cnt_s1 - amount_s1;
						rsp_next.count_value = wr_cnt;
					end
				end else begin
					rsp_next.status = ST_NOT_FOUND;
				end
			end
			OP_QUERY: begin
				if (hit_s1) rsp_next.count_value = cnt_s1;
			end
			OP_CLEAR: begin
				clr_all      = 1'b1;
				occ_next     = '0;
				rsp_next.hit = 1'b0;
			end
		endcase
		occ_ext              = {5'b0, occ_next};
		rsp_next.occupied    = occ_ext[4:0];
		rsp_next.table_empty = (occ_next == '0);
	end

	// entry payload: no reset, read only while valid
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			counts_q[wr_idx] <= wr_cnt;
			if (wr_key_en) keys_q[wr_idx] <= key_s1;
		end
		if (cmd.commit) rsp_q <= rsp_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.commit) begin
			occ_q <= occ_next;
			if (clr_all) begin
				valid_q <= '0;
			end else if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	assign rsp_data     = rsp_q;
	assign st.occ       = occ_q;
	assign st.valid_vec = valid_q;

endmodule

### src/keyed_quantity_table.sv
// Keyed quantity table: 16-entry associative (key, count) store.
// Flow: the key is matched when the request beat is accepted; the entry is then
// updated and the response loaded at commit. No new request is accepted before that
// commit (match-then-update on the shared entry registers); a held response stalls it.
// Reset: arst_n clears all entry valid bits, the occupancy count and the FSM.
`timescale 1ns / 1ps

module keyed_quantity_table
	import kqt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	dp_cmd_t cmd;
	dp_st_t  st;

	// Sequencer: accept a beat in idle, commit it once the response
	// register is free, then go back to idle.
	kqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Datapath: the accepted key is matched against every entry at the
	// accept edge; the chosen entry is updated and the response loaded on
	// the commit edge.
	kqt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.rsp_data (rsp_data),
		.st       (st)
	);

`ifndef SYNTHESIS
	// occupancy counter tracks the valid bits
	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(st.valid_vec) == int'(st.occ))
		else $error("occupancy count disagrees with valid bits");

	// one beat in flight: an accept is followed by the update cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// a full-table response never reports a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_FULL |-> !rsp_data.hit)
		else $error("table full reported together with a hit");

	// an empty table holds no count for any key
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.table_empty |-> rsp_data.count_value == '0)
		else $error("nonzero count reported with an empty table");
`endif

endmodule

### bench/kqt_checker.sv
// Checker for the keyed quantity table: watches both channels, keeps its own
// copy of the table to predict each response and compares it field by field.
// Depends on kqt_pkg for the beat structs, sizes and codes.
`timescale 1ns / 1ps

module kqt_checker
	import kqt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_data,
	output int   mismatches,
	output int   outstanding,
	output int   answered,
	output int   full_rejects,
	output int   missing_removes,
	output int   capped_adds,
	output int   freed_entries,
	output int   peak_occupancy
);

	logic [KEY_W-1:0] shelf_key [ENTRIES];
	logic [CNT_W-1:0] shelf_qty [ENTRIES];
	bit               shelf_used[ENTRIES];
	rsp_t             owed_results[$];

	// Apply one request to the shadow table and return the response it owes.
	function automatic rsp_t apply_to_shelf(req_t beat);
		rsp_t           r;
		int             slot;
		int             spare;
		int             used;
		logic [CNT_W:0] sum;
		r = '0;
		slot = -1;
		spare = -1;
		if (beat.kind == OP_CLEAR) begin
			foreach (shelf_used[i]) shelf_used[i] = 1'b0;
		end else begin
			// scan downward so the lowest matching and lowest free slot win
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (shelf_used[i] && shelf_key[i] == beat.item_key) slot = i;
				if (!shelf_used[i]) spare = i;
			end
			r.hit = (slot >= 0);
			case (beat.kind)
				OP_ADD: begin
					if (slot >= 0) begin
						sum = shelf_qty[slot] + beat.amount;
						if (sum > {1'b0, {CNT_W{1'b1}}}) begin
							sum = {1'b0, {CNT_W{1'b1}}};
							capped_adds++;
						end
						shelf_qty[slot] = sum[CNT_W-1:0];
						r.count_value = sum[CNT_W-1:0];
					end else if (spare >= 0) begin
						shelf_key[spare] = beat.item_key;
						shelf_qty[spare] = beat.amount;
						shelf_used[spare] = 1'b1;
						r.count_value = beat.amount;
					end else begin
						r.status = ST_FULL;
						full_rejects++;
					end
				end
				OP_REMOVE: begin
					if (slot < 0) begin
						r.status = ST_NOT_FOUND;
						missing_removes++;
					end else if (beat.amount >= shelf_qty[slot]) begin
						shelf_used[slot] = 1'b0;
						freed_entries++;
					end else begin
						shelf_qty[slot] = shelf_qty[slot] - beat.amount;
						r.count_value = shelf_qty[slot];
					end
				end
				OP_QUERY: begin
					if (slot >= 0) r.count_value = shelf_qty[slot];
				end
			endcase
		end
		used = 0;
		foreach (shelf_used[i]) if (shelf_used[i]) used++;
		r.occupied = used[4:0];
		r.table_empty = (used == 0);
		if (used > peak_occupancy) peak_occupancy = used;
		return r;
	endfunction

	function automatic void check_field(string field, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (shelf_used[i]) shelf_used[i] = 1'b0;
			owed_results.delete();
		end else begin
			// settle the response first; the latency rules out one from this beat
			if (rsp_valid && rsp_ready) begin
				answered++;
				if (owed_results.size() == 0) begin
					mismatches++;
					$error("response beat with no request outstanding");
				end else begin
					want = owed_results.pop_front();
					check_field("count_value", want.count_value, rsp_data.count_value);
					check_field("hit", CNT_W'(want.hit), CNT_W'(rsp_data.hit));
					check_field("status", CNT_W'(want.status),
						CNT_W'(rsp_data.status));
					check_field("occupied", CNT_W'(want.occupied),
						CNT_W'(rsp_data.occupied));
					check_field("table_empty", CNT_W'(want.table_empty),
						CNT_W'(rsp_data.table_empty));
				end
			end
			if (req_valid && req_ready) owed_results.push_back(apply_to_shelf(req_data));
		end
		outstanding = owed_results.size();
	end

endmodule

### bench/tb_keyed_quantity_table.sv
// Testbench top for the keyed quantity table: drives request beats, paces the
// response side and gives the verdict; prediction lives in kqt_checker.
// Depends on kqt_pkg, keyed_quantity_table and kqt_checker.
`timescale 1ns / 1ps

module tb_keyed_quantity_table;
	import kqt_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// pacing knobs, changed between stimulus phases
	int send_idle_pct = 30;
	int recv_idle_pct = 78;
	bit long_hold_wanted = 1'b0;

	int mismatches;
	int outstanding;
	int answered;
	int full_rejects;
	int missing_removes;
	int capped_adds;
	int freed_entries;
	int peak_occupancy;

	// keys that random beats mostly draw from, so hits, frees and a full
	// table all come up often; the pool is larger than the table on purpose
	logic [KEY_W-1:0] key_pool[20];

	keyed_quantity_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	kqt_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_data       (req_data),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp_data       (rsp_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.answered       (answered),
		.full_rejects   (full_rejects),
		.missing_removes(missing_removes),
		.capped_adds    (capped_adds),
		.freed_entries  (freed_entries),
		.peak_occupancy (peak_occupancy)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	// Response side: stall at the current rate; on request, hold off for a
	// long stretch so the block backs up and has to drop req_ready.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_wanted && hold_left == 0) begin
				hold_left = 150;
				long_hold_wanted = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one beat. An optional gap drops valid first; without a gap valid
	// stays high and only the payload changes, so it is never lowered and
	// raised in the same step. Return at the edge that accepts the beat.
	task automatic offer(input logic [1:0] kind, input logic [KEY_W-1:0] key,
			input logic [CNT_W-1:0] amount);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data  <= '{kind: kind, item_key: key, amount: amount};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// One random beat: mostly adds and removes on pooled keys, a few stray
	// keys and the odd clear to keep occupancy moving.
	task automatic offer_random();
		int               pick;
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] amount;
		pick = $urandom_range(99);
		kind = (pick < 45) ? OP_ADD : (pick < 75) ? OP_REMOVE :
			(pick < 96) ? OP_QUERY : OP_CLEAR;
		if ($urandom_range(99) < 85) key = key_pool[$urandom_range(19)];
		else key = KEY_W'($urandom);
		// small amounts keep counts alive; extremes force saturation and frees
		case ($urandom_range(9))
			0:       amount = '0;
			1:       amount = '1;
			2, 3:    amount = CNT_W'($urandom);
			default: amount = CNT_W'($urandom_range(1, 40));
		endcase
		offer(kind, key, amount);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill every slot with keys and amounts from zero to all
		// ones, so each key and amount bit toggles and the first slot holds a
		// zero count.
		offer(OP_CLEAR, '0, '0);
		for (int i = 0; i < ENTRIES; i++) begin
			offer(OP_ADD, KEY_W'(i * 'h1111), CNT_W'(i * 'h1111));
		end
		offer(OP_ADD, 16'h1234, 16'd7);        // new key on a full table
		offer(OP_ADD, 16'hFFFF, 16'd1);        // count sticks at the maximum
		offer(OP_QUERY, 16'hFFFF, 16'h5A5A);   // amount ignored
		offer(OP_REMOVE, 16'h0000, 16'h0000);  // zero count: entry freed
		offer(OP_REMOVE, 16'h1111, 16'd1);     // partial remove
		offer(OP_REMOVE, 16'h2222, 16'hFFFF);  // remove more than held
		offer(OP_REMOVE, 16'h1234, 16'd3);     // absent key
		offer(OP_QUERY, 16'h1234, 16'h0000);   // absent key reads zero
		offer(OP_ADD, 16'h1234, 16'h0000);     // zero amount claims a slot
		offer(OP_QUERY, 16'h1234, 16'hFFFF);
		offer(OP_CLEAR, 16'hFFFF, 16'hFFFF);
		offer(OP_QUERY, 16'hFFFF, 16'h0000);   // gone after clear

		foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);

		// Random: fast sender against a slow receiver, then swapped, then
		// full speed with one long receiver hold-off at its start.
		repeat (300) offer_random();
		send_idle_pct = 78;
		recv_idle_pct = 30;
		repeat (300) offer_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_wanted = 1'b1;
		repeat (300) offer_random();
		req_valid <= 1'b0;

		// drain, then give the block a few cycles to show any stray beat
		wait (outstanding == 0);
		repeat (20) @(posedge clk);

		$display("checked %0d responses; peak occupancy %0d, %0d adds on a full table,",
			answered, peak_occupancy, full_rejects);
		$display("%0d removes of absent keys, %0d saturating adds, %0d entries freed",
			missing_removes, capped_adds, freed_entries);
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
